/* src/archive_directory_deframe_decrypt_macros.svh */
// Assertion macros used by the directory deframer parser, addd_parse.
// Include by bare file name; no other dependencies.
`ifndef ARCHIVE_DIRECTORY_DEFRAME_DECRYPT_MACROS_SVH
`define ARCHIVE_DIRECTORY_DEFRAME_DECRYPT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ADDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("addd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ADDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("addd assertion failed");

`endif

/* src/addd_pkg.sv */
// Types and constants for the archive directory deframer and decryptor.
// No dependencies.
package addd_pkg;

    // Kind of result byte
    localparam logic [1:0] KIND_LEN_LO = 2'd0;
    localparam logic [1:0] KIND_LEN_HI = 2'd1;
    localparam logic [1:0] KIND_BODY   = 2'd2;

    localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

    // Input request payload
    typedef struct packed {
        logic       start_of_table;
        logic [7:0] table_byte;
    } in_t;

    // Result request payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       entry_last;
        logic       past_table_end;
    } out_t;

    // Result handed from the parser to the output register
    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

    // Keystream byte selected by the low nibble of the chained key
    function automatic logic [7:0] key_table(input logic [3:0] idx);
        logic [7:0] k;
        case (idx)
            4'h0:    k = 8'h32;
            4'h1:    k = 8'hF3;
            4'h2:    k = 8'h1E;
            4'h3:    k = 8'h06;
            4'h4:    k = 8'h45;
            4'h5:    k = 8'h70;
            4'h6:    k = 8'h32;
            4'h7:    k = 8'hAA;
            4'h8:    k = 8'h55;
            4'h9:    k = 8'h3F;
            4'hA:    k = 8'hF1;
            4'hB:    k = 8'hDE;
            4'hC:    k = 8'hA3;
            4'hD:    k = 8'h44;
            4'hE:    k = 8'h21;
            default: k = 8'hB4;
        endcase
        return k;
    endfunction

endpackage

/* src/archive_directory_deframe_decrypt.sv */
// Archive directory deframer and decryptor, top level.
// Depends on addd_pkg, addd_parse and addd_outreg.
//
// Takes one directory-table byte per cycle and returns at most one result
// per byte: length bytes unchanged, body bytes XOR-decrypted with a key chained
// through the previous cipher byte. Every byte is parsed in the cycle it is
// accepted and its result appears on the output in the next cycle, so the
// sustained rate is one byte per clock; the output register is the only stage.
// The input stalls only while a result is held and the output stalls. Write
// table_size through cfg_wr_en/cfg_wr_data while no bytes are in flight.
module archive_directory_deframe_decrypt
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  addd_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output addd_pkg::out_t   out_data
);

    logic           accept;
    addd_pkg::res_t res;

    assign accept = in_valid && !in_stall;

    addd_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_data     (in_data),
        .res         (res)
    );

    addd_outreg u_outreg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .res       (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* src/addd_parse.sv */
// Entry parser: position tracking, length capture and body decryption.
// Depends on addd_pkg and archive_directory_deframe_decrypt_macros.svh.
`include "archive_directory_deframe_decrypt_macros.svh"

module addd_parse
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  logic             accept,
    input  addd_pkg::in_t    in_data,
    output addd_pkg::res_t   res
);

    typedef enum logic [1:0] {
        PH_LEN_LO = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [31:0] size_reg;
    logic [31:0] pos_reg, pos_next, pos_cur;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] rem_reg, rem_next, rem_dec;
    logic [7:0]  key_reg, key_next;
    logic [15:0] len;
    logic [7:0]  b;
    logic        past_end;
    logic        room;

    // Resolve restart and compute the result for this byte
    always_comb
    begin
        b         = in_data.table_byte;
        phase_cur = in_data.start_of_table ? PH_LEN_LO : phase_reg;
        pos_cur   = in_data.start_of_table ? 32'd0 : pos_reg;
        past_end  = (pos_cur >= size_reg);
        room      = ({1'b0, pos_cur} + 33'd2) < {1'b0, size_reg};
        len       = {b, len_lo_reg};
        rem_dec   = rem_reg - 16'd1;

        phase_next  = phase_cur;
        len_lo_next = len_lo_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        res         = '0;

        case (phase_cur)
            PH_LEN_HI:
            begin
                rem_next                = len;
                key_next                = len_lo_reg;
                phase_next              = (len == 16'd0) ? PH_LEN_LO : PH_BODY;
                res.valid               = 1'b1;
                res.data.out_byte       = b;
                res.data.byte_kind      = addd_pkg::KIND_LEN_HI;
                res.data.entry_last     = (len == 16'd0);
                res.data.past_table_end = past_end;
            end
            PH_BODY:
            begin
                key_next                = b;
                rem_next                = rem_dec;
                phase_next              = (rem_dec == 16'd0) ? PH_LEN_LO : PH_BODY;
                res.valid               = 1'b1;
                res.data.out_byte       = b ^ addd_pkg::key_table(key_reg[3:0]);
                res.data.byte_kind      = addd_pkg::KIND_BODY;
                res.data.entry_last     = (rem_dec == 16'd0);
                res.data.past_table_end = past_end;
            end
            default:
            begin
                // Start an entry only if this byte and two more fit before the table end
                phase_next = PH_LEN_LO;
                if (room)
                begin
                    len_lo_next        = b;
                    phase_next         = PH_LEN_HI;
                    res.valid          = 1'b1;
                    res.data.out_byte  = b;
                    res.data.byte_kind = addd_pkg::KIND_LEN_LO;
                end
            end
        endcase

        // Advance position, saturating at the top
        pos_next = (pos_cur == addd_pkg::POS_MAX) ? pos_cur : pos_cur + 32'd1;
    end

    // Hold table size and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= '0;
            phase_reg  <= PH_LEN_LO;
            pos_reg    <= '0;
            len_lo_reg <= '0;
            rem_reg    <= '0;
            key_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                len_lo_reg <= len_lo_next;
                rem_reg    <= rem_next;
                key_reg    <= key_next;
            end
        end
    end

    `ADDD_ASSERT_IMP(a_body_has_bytes, clk, rst_n, phase_reg == PH_BODY, rem_reg != 16'd0)
    `ADDD_ASSERT_NXT(a_lo_then_hi, clk, rst_n,
        accept && res.valid && res.data.byte_kind == addd_pkg::KIND_LEN_LO,
        phase_reg == PH_LEN_HI)
    `ADDD_ASSERT_NXT(a_last_ends_entry, clk, rst_n,
        accept && res.valid && res.data.entry_last, phase_reg == PH_LEN_LO)
    `ADDD_ASSERT_NXT(a_pos_saturates, clk, rst_n,
        accept && !in_data.start_of_table && pos_reg == addd_pkg::POS_MAX,
        pos_reg == addd_pkg::POS_MAX)

endmodule

/* src/addd_outreg.sv */
// Output register: holds one result request and decouples the two channels.
// Depends on addd_pkg.
module addd_outreg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  addd_pkg::res_t   res,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output addd_pkg::out_t   out_data
);

    logic           valid_reg;
    addd_pkg::out_t data_reg;
    logic           load;

    // Load whenever the held request is absent or being taken
    assign load     = !valid_reg || !out_stall;
    assign in_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= accept && res.valid;
        end
    end

    // Capture payload with the request
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res.data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* tb/tb_archive_directory_deframe_decrypt.sv */
// Self-checking testbench for archive_directory_deframe_decrypt.
// Depends on addd_pkg and the archive_directory_deframe_decrypt RTL; nothing else.
// Streams directory tables through the block and checks every result against a local predictor.
module tb_archive_directory_deframe_decrypt;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 60;

    typedef enum logic [1:0]
    {
        AWAIT_LEN_LO = 2'd0,
        AWAIT_LEN_HI = 2'd1,
        IN_BODY      = 2'd2
    } parse_phase_t;

    localparam logic [7:0] KEYSTREAM [16] = '{
        8'h32, 8'hF3, 8'h1E, 8'h06, 8'h45, 8'h70, 8'h32, 8'hAA,
        8'h55, 8'h3F, 8'hF1, 8'hDE, 8'hA3, 8'h44, 8'h21, 8'hB4
    };

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [31:0]     cfg_wr_data = '0;
    logic            in_valid    = 1'b0;
    logic            in_stall;
    addd_pkg::in_t   in_data     = '0;
    logic            out_valid;
    logic            out_stall   = 1'b0;
    addd_pkg::out_t  out_data;

    // Predictor state
    logic [31:0]  model_size;
    logic [31:0]  model_pos;
    parse_phase_t model_phase;
    logic [7:0]   model_len_lo;
    logic [15:0]  model_left;
    logic [7:0]   model_key;

    addd_pkg::out_t pending_results [$];
    int   predicted_count = 0;
    int   err_count       = 0;
    int   quiet_cycles    = 0;

    // Idle controls
    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int burst_left   = 0;

    archive_directory_deframe_decrypt i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // Advance the predictor by one accepted request and queue its result, if any
    task automatic predict_table_byte(input addd_pkg::in_t req);
        logic [31:0]    here;
        logic [15:0]    len;
        addd_pkg::out_t res;
        bit             produced;
        produced = 1'b0;
        res      = '0;
        if (req.start_of_table)
        begin
            model_pos   = '0;
            model_phase = AWAIT_LEN_LO;
        end
        here = model_pos;
        case (model_phase)
            AWAIT_LEN_HI:
            begin
                len                = {req.table_byte, model_len_lo};
                model_left         = len;
                model_key          = model_len_lo;
                res.out_byte       = req.table_byte;
                res.byte_kind      = addd_pkg::KIND_LEN_HI;
                res.entry_last     = (len == 16'd0);
                res.past_table_end = (here >= model_size);
                if (len == 16'd0)
                    model_phase = AWAIT_LEN_LO;
                else
                    model_phase = IN_BODY;
                produced = 1'b1;
            end
            IN_BODY:
            begin
                res.out_byte       = req.table_byte ^ KEYSTREAM[model_key[3:0]];
                res.byte_kind      = addd_pkg::KIND_BODY;
                model_key          = req.table_byte;
                model_left         = model_left - 16'd1;
                res.entry_last     = (model_left == 16'd0);
                res.past_table_end = (here >= model_size);
                if (model_left == 16'd0)
                    model_phase = AWAIT_LEN_LO;
                produced = 1'b1;
            end
            default:
            begin
                // An entry opens only while two more bytes still fit in the table
                model_phase = AWAIT_LEN_LO;
                if ({1'b0, here} + 33'd2 < {1'b0, model_size})
                begin
                    model_len_lo       = req.table_byte;
                    res.out_byte       = req.table_byte;
                    res.byte_kind      = addd_pkg::KIND_LEN_LO;
                    res.entry_last     = 1'b0;
                    res.past_table_end = 1'b0;
                    model_phase        = AWAIT_LEN_HI;
                    produced           = 1'b1;
                end
            end
        endcase
        if (model_pos != addd_pkg::POS_MAX)
            model_pos = model_pos + 32'd1;
        if (produced)
        begin
            pending_results.insert(pending_results.size(), res);
            predicted_count++;
        end
    endtask

    // Check results first, then predict, so a fresh request never matches this edge
    always @(posedge clk)
    begin
        addd_pkg::out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", 32'(out_data), 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 32'(out_data.out_byte),
                                        32'(want.out_byte));
                    if (out_data.byte_kind !== want.byte_kind)
                        report_mismatch("byte_kind", 32'(out_data.byte_kind),
                                        32'(want.byte_kind));
                    if (out_data.entry_last !== want.entry_last)
                        report_mismatch("entry_last", 32'(out_data.entry_last),
                                        32'(want.entry_last));
                    if (out_data.past_table_end !== want.past_table_end)
                        report_mismatch("past_table_end", 32'(out_data.past_table_end),
                                        32'(want.past_table_end));
                end
            end
            if (in_valid && !in_stall)
                predict_table_byte(in_data);
        end
    end

    // Result side: long hold on request, otherwise short random stall bursts
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (burst_left > 0)
        begin
            out_stall <= 1'b1;
            burst_left--;
        end
        else if (rx_gaps && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            burst_left = $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request and hold it until accepted; valid stays high afterwards
    task automatic send_byte(input logic sot, input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {sot, b};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid, wait for all pending results, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_table_size(input logic [31:0] size);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        model_size = size;
    endtask

    // Send one entry: length bytes then a random body, with optional stray restarts
    task automatic send_entry(input logic sot, input logic [15:0] len, input int n_body,
                              input bit stray);
        int i;
        send_byte(sot, len[7:0]);
        send_byte(1'b0, len[15:8]);
        for (i = 0; i < n_body; i++)
            send_byte(stray && $urandom_range(0, 39) == 0, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_size_reset_value();
        // Size is zero out of reset, so nothing may open an entry
        send_byte(1'b1, 8'hA5);
        send_byte(1'b0, 8'h00);
    endtask

    task automatic test_zero_and_max_length();
        int i;
        set_table_size(addd_pkg::POS_MAX);
        // Zero-length entry ends on its length high byte
        send_entry(1'b1, 16'h0000, 0, 1'b0);
        // Maximum length, cut short by a restart
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h5A);
        send_byte(1'b0, 8'hC3);
        send_byte(1'b0, 8'h0F);
        send_entry(1'b1, 16'h0003, 3, 1'b0);
        send_byte(1'b0, 8'h7E);
    endtask

    task automatic test_tiny_tables();
        // Entry overruns a three-byte table, then no room for another
        set_table_size(32'd3);
        send_entry(1'b1, 16'h0002, 2, 1'b0);
        send_byte(1'b0, 8'h44);
        set_table_size(32'd2);
        send_byte(1'b1, 8'h01);
        set_table_size(32'd1);
        send_byte(1'b1, 8'h01);
    endtask

    task automatic test_input_backpressure();
        set_table_size(32'd1000);
        hold_request = 1'b1;
        send_entry(1'b1, 16'd10, 10, 1'b0);
        send_entry(1'b0, 16'd12, 12, 1'b0);
        send_entry(1'b0, 16'd8, 8, 1'b0);
    endtask

    // Mostly well-formed tables with random content, sizes that fit, overrun or leave slack
    task automatic test_random_tables(input int n_results, input bit gaps);
        int          target;
        int          n_ent;
        int          lens [4];
        int          total;
        int          pad;
        int          mode;
        int          r;
        int          i;
        logic [31:0] size;
        target  = predicted_count + n_results;
        tx_gaps = gaps;
        rx_gaps = gaps;
        while (predicted_count < target)
        begin
            n_ent = $urandom_range(1, 4);
            total = 0;
            for (i = 0; i < n_ent; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    lens[i] = $urandom_range(0, 6);
                else if (r < 95)
                    lens[i] = $urandom_range(7, 20);
                else
                    lens[i] = $urandom_range(21, 60);
                total += lens[i] + 2;
            end
            pad  = 0;
            mode = $urandom_range(0, 99);
            if (mode < 55)
                size = total;
            else if (mode < 70)
                size = total - $urandom_range(1, (total > 6) ? 6 : total - 1);
            else if (mode < 85)
            begin
                pad  = $urandom_range(1, 4);
                size = total + pad;
            end
            else
                size = $urandom;
            set_table_size(size);
            for (i = 0; i < n_ent; i++)
                send_entry(i == 0, 16'(lens[i]), lens[i], 1'b1);
            for (i = 0; i < pad; i++)
                send_byte(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    // Unstructured bytes and restarts under assorted sizes
    task automatic test_noise();
        int i;
        for (i = 0; i < 60; i++)
        begin
            if (i % 15 == 0)
            begin
                case (i / 15)
                    0:       set_table_size(32'd0);
                    1:       set_table_size(32'($urandom_range(0, 8)));
                    2:       set_table_size($urandom);
                    default: set_table_size(addd_pkg::POS_MAX);
                endcase
            end
            send_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        model_size   = '0;
        model_pos    = '0;
        model_phase  = AWAIT_LEN_LO;
        model_len_lo = '0;
        model_left   = '0;
        model_key    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_reset_value();
        test_zero_and_max_length();
        test_tiny_tables();
        test_input_backpressure();
        test_random_tables(420, 1'b1);
        test_noise();
        test_random_tables(110, 1'b0);

        wait_drained();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/addd_pkg.sv
src/addd_parse.sv
src/addd_outreg.sv
src/archive_directory_deframe_decrypt.sv
tb/tb_archive_directory_deframe_decrypt.sv
